@@ sv/tlik_pkg.sv @@
package tlik_pkg;

  localparam int unsigned CoordBits    = 16;
  localparam int unsigned CordicStages = 16;
  localparam int unsigned LenBits      = 16;
  localparam int unsigned AngBits      = 16;
  localparam int unsigned ElbowBits    = 15;

  // cos/sin are Q1.30
  localparam int unsigned FracBits = 30;
  localparam int unsigned QBits    = 32;

  // CORDIC datapath width: operands below 2^30 grow by at most ~1.65x
  localparam int unsigned CxBits = 33;
  localparam int unsigned ZBits  = 32;

  localparam logic [ZBits-1:0] Z90 = 32'd5898240;

  typedef enum logic {
    CFG_FIRST_LINK  = 1'b0,
    CFG_SECOND_LINK = 1'b1
  } cfg_idx_e;

  localparam logic [LenBits-1:0] LenReset = 16'd2048;

  typedef struct packed {
    logic signed [CoordBits-1:0] target_x;
    logic signed [CoordBits-1:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic signed [AngBits-1:0] shoulder_angle;
    logic        [ElbowBits-1:0] elbow_angle;
    logic                        reachable;
  } out_item_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic [ZBits-1:0] atan_tab(input logic [4:0] i);
    logic [ZBits-1:0] r;
    case (i)
      5'd0:  r = 32'd2949120;
      5'd1:  r = 32'd1740967;
      5'd2:  r = 32'd919879;
      5'd3:  r = 32'd466945;
      5'd4:  r = 32'd234379;
      5'd5:  r = 32'd117304;
      5'd6:  r = 32'd58666;
      5'd7:  r = 32'd29335;
      5'd8:  r = 32'd14668;
      5'd9:  r = 32'd7334;
      5'd10: r = 32'd3667;
      5'd11: r = 32'd1833;
      5'd12: r = 32'd917;
      5'd13: r = 32'd458;
      5'd14: r = 32'd229;
      5'd15: r = 32'd115;
      5'd16: r = 32'd57;
      5'd17: r = 32'd29;
      5'd18: r = 32'd14;
      5'd19: r = 32'd7;
      5'd20: r = 32'd4;
      5'd21: r = 32'd2;
      5'd22: r = 32'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/tlik_cordic_stage.sv @@
// One vectoring micro-rotation, registered, with side data carried along.
module tlik_cordic_stage #(
  parameter int unsigned Idx   = 0,
  parameter int unsigned SideW = 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic signed [tlik_pkg::CxBits-1:0]     x_i,
  input  logic signed [tlik_pkg::CxBits-1:0]     y_i,
  input  logic signed [tlik_pkg::ZBits-1:0]      z_i,
  input  logic [SideW-1:0]                       side_i,
  output logic                                   valid_o,
  output logic signed [tlik_pkg::CxBits-1:0]     x_o,
  output logic signed [tlik_pkg::CxBits-1:0]     y_o,
  output logic signed [tlik_pkg::ZBits-1:0]      z_o,
  output logic [SideW-1:0]                       side_o
);
  logic signed [tlik_pkg::CxBits-1:0] dx, dy, x_d, y_d;
  logic signed [tlik_pkg::ZBits-1:0]  a, z_d;
  logic valid_q;
  logic signed [tlik_pkg::CxBits-1:0] x_q, y_q;
  logic signed [tlik_pkg::ZBits-1:0]  z_q;
  logic [SideW-1:0] side_q;

  always_comb begin
    dx = y_i >>> Idx;
    dy = x_i >>> Idx;
    a  = tlik_pkg::atan_tab(5'(Idx));
    if (!y_i[tlik_pkg::CxBits-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + a;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;
endmodule

@@ sv/tlik_atan2.sv @@
// Pipelined atan2: normalize over 2 stages (the second also pre-rotates), then one stage per
// iteration and a final register. Inputs are 64-bit signed.
module tlik_atan2 #(
  parameter int unsigned Stages = tlik_pkg::CordicStages,
  parameter int unsigned SideW  = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [63:0]                y_i,
  input  logic signed [63:0]                x_i,
  input  logic [SideW-1:0]                  side_i,
  output logic                              valid_o,
  output logic signed [tlik_pkg::ZBits-1:0] z_o,
  output logic [SideW-1:0]                  side_o
);
  localparam int unsigned CW = tlik_pkg::CxBits;
  localparam int unsigned ZW = tlik_pkg::ZBits;

  // stage A: leading-bit position of max magnitude
  logic [63:0] mx, my, mor;
  logic [6:0]  lead;
  logic        zero_a;
  always_comb begin
    mx = x_i[63] ? 64'(-x_i) : 64'(x_i);
    my = y_i[63] ? 64'(-y_i) : 64'(y_i);
    mor = (mx > my) ? mx : my;
    lead = '0;
    for (int b = 0; b < 64; b++) begin
      if (mor[b]) lead = 7'(b);
    end
    zero_a = (x_i == '0) && (y_i == '0);
  end

  logic               va_q, zero_q;
  logic signed [63:0] xa_q, ya_q;
  logic [6:0]         lead_q;
  logic [SideW-1:0]   sa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en_i) va_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q <= x_i; ya_q <= y_i; lead_q <= lead; zero_q <= zero_a; sa_q <= side_i;
    end
  end

  // stage B: shift so that the top magnitude bit sits at bit 29, then pre-rotate
  logic signed [63:0] xs, ys;
  logic signed [CW-1:0] xb, yb;
  logic signed [ZW-1:0] zb;
  always_comb begin
    if (lead_q >= 7'd29) begin
      xs = xa_q >>> (lead_q - 7'd29);
      ys = ya_q >>> (lead_q - 7'd29);
      // floor shift can round a negative operand onto -2^30; take one more step
      if (xs == -(64'sd1 <<< 30) || ys == -(64'sd1 <<< 30)) begin
        xs = xs >>> 1;
        ys = ys >>> 1;
      end
    end else begin
      xs = xa_q <<< (7'd29 - lead_q);
      ys = ya_q <<< (7'd29 - lead_q);
    end
    xb = CW'(xs);
    yb = CW'(ys);
    zb = '0;
    if (xs[63]) begin
      if (!ys[63]) begin
        xb = CW'(ys); yb = CW'(-xs); zb = tlik_pkg::Z90;
      end else begin
        xb = CW'(-ys); yb = CW'(xs); zb = ZW'(-tlik_pkg::Z90);
      end
    end
  end

  logic                 vb_q, zb0_q;
  logic signed [CW-1:0] xb_q, yb_q;
  logic signed [ZW-1:0] zb_q;
  logic [SideW-1:0]     sb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en_i) vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xb_q <= xb; yb_q <= yb; zb_q <= zb; zb0_q <= zero_q; sb_q <= sa_q;
    end
  end

  logic                 v [Stages+1];
  logic signed [CW-1:0] xc [Stages+1];
  logic signed [CW-1:0] yc [Stages+1];
  logic signed [ZW-1:0] zc [Stages+1];
  logic [SideW:0]       sc [Stages+1];

  assign v[0]  = vb_q;
  assign xc[0] = xb_q;
  assign yc[0] = yb_q;
  assign zc[0] = zb_q;
  assign sc[0] = {zb0_q, sb_q};

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    tlik_cordic_stage #(.Idx(g), .SideW(SideW + 1)) u_stage (
      .clk_i, .rst_ni, .en_i,
      .valid_i(v[g]), .x_i(xc[g]), .y_i(yc[g]), .z_i(zc[g]), .side_i(sc[g]),
      .valid_o(v[g+1]), .x_o(xc[g+1]), .y_o(yc[g+1]), .z_o(zc[g+1]), .side_o(sc[g+1])
    );
  end

  // final register zeroes the degenerate case
  logic                 vo_q;
  logic signed [ZW-1:0] zo_q;
  logic [SideW-1:0]     so_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en_i) vo_q <= v[Stages];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zo_q <= sc[Stages][SideW] ? '0 : zc[Stages];
      so_q <= sc[Stages][SideW-1:0];
    end
  end

  assign valid_o = vo_q;
  assign z_o     = zo_q;
  assign side_o  = so_q;
endmodule

@@ sv/tlik_cos_sin.sv @@
// Front end: r^2 vs link terms, cos by restoring division, sin by digit-per-stage sqrt.
// Divider emits one quotient bit per stage; sqrt one result bit per stage.
module tlik_cos_sin (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  tlik_pkg::in_item_t                    item_i,
  input  logic [tlik_pkg::LenBits-1:0]          l1_i,
  input  logic [tlik_pkg::LenBits-1:0]          l2_i,
  output logic                                  valid_o,
  output logic                                  reach_o,
  output logic signed [tlik_pkg::QBits-1:0]     cos_o,
  output logic [tlik_pkg::QBits-1:0]            sin_o,
  output tlik_pkg::in_item_t                    item_o,
  output logic [tlik_pkg::LenBits-1:0]          l1_o,
  output logic [tlik_pkg::LenBits-1:0]          l2_o
);
  localparam int unsigned DivSteps = 31;  // quotient up to 2^30 needs 31 bits
  localparam int unsigned SqSteps  = 31;

  // carried context
  typedef struct packed {
    tlik_pkg::in_item_t          item;
    logic [tlik_pkg::LenBits-1:0] l1;
    logic [tlik_pkg::LenBits-1:0] l2;
  } ctx_t;

  // stage 1: squares and products
  logic [31:0] ax, ay;
  ctx_t c1_q;
  logic v1_q;
  logic [31:0] x2_q, y2_q, l11_q, l22_q, l12_q;
  always_comb begin
    ax = item_i.target_x[15] ? 32'(-33'(item_i.target_x)) : 32'(item_i.target_x);
    ay = item_i.target_y[15] ? 32'(-33'(item_i.target_y)) : 32'(item_i.target_y);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q  <= '{item: item_i, l1: l1_i, l2: l2_i};
      x2_q  <= ax[15:0] == 16'h0 && ax[16] ? 32'h4000_0000 : ax * ax;
      y2_q  <= ay[15:0] == 16'h0 && ay[16] ? 32'h4000_0000 : ay * ay;
      l11_q <= 32'(l1_i) * 32'(l1_i);
      l22_q <= 32'(l2_i) * 32'(l2_i);
      l12_q <= 32'(l1_i) * 32'(l2_i);
    end
  end

  // stage 2: numerator magnitude, denominator, reach test
  logic [33:0] r2, ls, an, dn;
  logic        ng;
  always_comb begin
    r2 = 34'(x2_q) + 34'(y2_q);
    ls = 34'(l11_q) + 34'(l22_q);
    ng = r2 < ls;
    an = ng ? ls - r2 : r2 - ls;
    dn = 34'({l12_q, 1'b0});
  end
  logic v2_q, ok2_q, ng2_q;
  logic [33:0] an2_q, dn2_q;
  ctx_t c2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en_i) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok2_q <= (dn != '0) && !(an > dn);
      ng2_q <= ng;
      an2_q <= an;
      dn2_q <= dn;
      c2_q  <= c1_q;
    end
  end

  // restoring division of (an<<30) + dn/2 by dn; an <= dn so quotient < 2^31
  // remainder pipeline: rem starts as dividend bits above 31 quotient positions
  localparam int unsigned DvW = 34 + 31;
  logic           dv   [DivSteps+1];
  logic [DvW-1:0] dnum [DivSteps+1];
  logic [34:0]    drem [DivSteps+1];
  logic [33:0]    dden [DivSteps+1];
  logic [30:0]    dq   [DivSteps+1];
  logic           dok  [DivSteps+1];
  logic           dng  [DivSteps+1];
  ctx_t           dctx [DivSteps+1];

  // (an<<30)+dn/2 fits in 65 bits; quotient bits 30..0, remainder prefix = bits 64..31
  logic [DvW-1:0] dividend;
  assign dividend = ({31'b0, an2_q} << 30) + DvW'(dn2_q >> 1);
  assign dv[0]   = v2_q;
  assign dnum[0] = dividend;
  assign drem[0] = {1'b0, dividend[DvW-1:31]};
  assign dden[0] = dn2_q;
  assign dq[0]   = '0;
  assign dok[0]  = ok2_q;
  assign dng[0]  = ng2_q;
  assign dctx[0] = c2_q;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    logic [34:0] t;
    logic [34:0] rn;
    logic        b;
    always_comb begin
      t  = {drem[g][33:0], dnum[g][30 - g]};
      b  = t >= {1'b0, dden[g]};
      rn = b ? t - {1'b0, dden[g]} : t;
    end
    logic v_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q <= 1'b0;
      else if (en_i) v_q <= dv[g];
    end
    logic [DvW-1:0] n_q; logic [34:0] r_q; logic [33:0] d_q; logic [30:0] q_q;
    logic o_q, s_q; ctx_t c_q;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q <= dnum[g]; r_q <= rn; d_q <= dden[g];
        q_q <= {dq[g][29:0], b}; o_q <= dok[g]; s_q <= dng[g]; c_q <= dctx[g];
      end
    end
    assign dv[g+1] = v_q; assign dnum[g+1] = n_q; assign drem[g+1] = r_q;
    assign dden[g+1] = d_q; assign dq[g+1] = q_q; assign dok[g+1] = o_q;
    assign dng[g+1] = s_q; assign dctx[g+1] = c_q;
  end

  // stage: 2^60 - cm^2
  logic [30:0] cmv;
  assign cmv = dok[DivSteps] ? dq[DivSteps] : '0;
  logic v3_q, ok3_q, ng3_q;
  logic [30:0] cm3_q;
  logic [61:0] rad3_q;
  ctx_t c3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en_i) v3_q <= dv[DivSteps];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok3_q  <= dok[DivSteps];
      ng3_q  <= dng[DivSteps];
      cm3_q  <= cmv;
      rad3_q <= (62'd1 << 60) - 62'(cmv) * 62'(cmv);
      c3_q   <= dctx[DivSteps];
    end
  end

  // digit-by-digit integer square root, one result bit per stage
  logic        sv   [SqSteps+1];
  logic [61:0] srad [SqSteps+1];
  logic [32:0] sres [SqSteps+1];
  logic [63:0] srem [SqSteps+1];
  logic        sok  [SqSteps+1];
  logic        sng  [SqSteps+1];
  logic [30:0] scm  [SqSteps+1];
  ctx_t        sctx [SqSteps+1];
  assign sv[0] = v3_q; assign srad[0] = rad3_q; assign sres[0] = '0; assign srem[0] = '0;
  assign sok[0] = ok3_q; assign sng[0] = ng3_q; assign scm[0] = cm3_q; assign sctx[0] = c3_q;

  for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
    logic [63:0] rm, tr;
    logic        b;
    always_comb begin
      rm = {srem[g][61:0], srad[g][61 - 2*g -: 2]};
      tr = {29'b0, sres[g], 2'b01};
      b  = rm >= tr;
    end
    logic v_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q <= 1'b0;
      else if (en_i) v_q <= sv[g];
    end
    logic [61:0] a_q; logic [32:0] s_q; logic [63:0] r_q; logic o_q, n_q;
    logic [30:0] m_q; ctx_t c_q;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q <= srad[g]; s_q <= {sres[g][31:0], b}; r_q <= b ? rm - tr : rm;
        o_q <= sok[g]; n_q <= sng[g]; m_q <= scm[g]; c_q <= sctx[g];
      end
    end
    assign sv[g+1] = v_q; assign srad[g+1] = a_q; assign sres[g+1] = s_q;
    assign srem[g+1] = r_q; assign sok[g+1] = o_q; assign sng[g+1] = n_q;
    assign scm[g+1] = m_q; assign sctx[g+1] = c_q;
  end

  assign valid_o = sv[SqSteps];
  assign reach_o = sok[SqSteps];
  assign cos_o   = sng[SqSteps] ? -$signed({1'b0, scm[SqSteps]}) : $signed({1'b0, scm[SqSteps]});
  assign sin_o   = 32'(sres[SqSteps]);
  assign item_o  = sctx[SqSteps].item;
  assign l1_o    = sctx[SqSteps].l1;
  assign l2_o    = sctx[SqSteps].l2;
endmodule

@@ sv/tlik_rotate.sv @@
// k1/k2 from cos/sin, then p/q. Multiplies split over stages, one register after each.
module tlik_rotate (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic                              reach_i,
  input  logic signed [tlik_pkg::QBits-1:0] cos_i,
  input  logic [tlik_pkg::QBits-1:0]        sin_i,
  input  tlik_pkg::in_item_t                item_i,
  input  logic [tlik_pkg::LenBits-1:0]      l1_i,
  input  logic [tlik_pkg::LenBits-1:0]      l2_i,
  output logic                              valid_o,
  output logic                              reach_o,
  output logic signed [tlik_pkg::QBits-1:0] cos_o,
  output logic [tlik_pkg::QBits-1:0]        sin_o,
  output logic signed [63:0]                p_o,
  output logic signed [63:0]                q_o
);
  typedef struct packed {
    logic                              reach;
    logic signed [tlik_pkg::QBits-1:0] c;
    logic [tlik_pkg::QBits-1:0]        s;
    tlik_pkg::in_item_t                item;
  } ctx_t;

  // stage 1: l2*c, l2*s (16x32)
  logic v1_q; ctx_t c1_q;
  logic signed [48:0] l2c_q; logic [47:0] l2s_q; logic [15:0] l1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q  <= '{reach: reach_i, c: cos_i, s: sin_i, item: item_i};
      l2c_q <= $signed({1'b0, l2_i}) * 49'(cos_i);
      l2s_q <= 48'(l2_i) * 48'(sin_i);
      l1_q  <= l1_i;
    end
  end

  // stage 2: k1, k2 floor-shifted by 17 (fit in ~33 bits)
  logic signed [49:0] k1f;
  always_comb k1f = $signed({1'b0, l1_q, 30'b0}) + 50'(l2c_q);
  logic v2_q; ctx_t c2_q;
  logic signed [33:0] k1_q, k2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en_i) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2_q <= c1_q;
      k1_q <= 34'(k1f >>> 17);
      k2_q <= $signed({3'b0, l2s_q[47:17]});
    end
  end

  // stage 3: four 34x16 products
  logic v3_q; ctx_t c3_q;
  logic signed [49:0] k1y_q, k2x_q, k1x_q, k2y_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en_i) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c3_q  <= c2_q;
      k1y_q <= k1_q * c2_q.item.target_y;
      k2x_q <= k2_q * c2_q.item.target_x;
      k1x_q <= k1_q * c2_q.item.target_x;
      k2y_q <= k2_q * c2_q.item.target_y;
    end
  end

  // stage 4: sums
  logic v4_q; ctx_t c4_q;
  logic signed [63:0] p_q, q_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en_i) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c4_q <= c3_q;
      p_q  <= 64'(k1y_q) - 64'(k2x_q);
      q_q  <= 64'(k1x_q) + 64'(k2y_q);
    end
  end

  assign valid_o = v4_q;
  assign reach_o = c4_q.reach;
  assign cos_o   = c4_q.c;
  assign sin_o   = c4_q.s;
  assign p_o     = p_q;
  assign q_o     = q_q;
endmodule

@@ sv/two_link_inverse_kinematics_top.sv @@
// Planar two-link inverse kinematics, elbow-down.
// Input channel: in_valid_i / in_stall_o carry a target point (Q8.8 x, y).
// Output channel: out_valid_o / out_stall_i carry shoulder and elbow angles in
// 1/128 degree plus a reachable flag; unreachable points give all zeros.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i (0: first link,
// 1: second link) and cfg_data_i; write only while the pipeline is empty.
// Throughput: one transaction per cycle, except while a stalled result holds the
// pipeline. Divider and square root stages dominate the latency; the shoulder and elbow
// CORDIC chains run side by side.
// The whole pipeline advances on one enable; a stalled valid result freezes every
// stage so nothing is lost or repeated, and in_stall_o follows out_stall_i
// whenever the last stage holds a result.
// Reset clears all valid bits and sets both links to 8.0 cm.
module two_link_inverse_kinematics_top #(
  parameter int unsigned CordicStages = tlik_pkg::CordicStages
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tlik_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tlik_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [tlik_pkg::LenBits-1:0]      cfg_data_i
);
  logic en;
  logic [tlik_pkg::LenBits-1:0] l1_q, l2_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= tlik_pkg::LenReset;
      l2_q <= tlik_pkg::LenReset;
    end else if (cfg_valid_i) begin
      case (tlik_pkg::cfg_idx_e'(cfg_index_i))
        tlik_pkg::CFG_FIRST_LINK:  l1_q <= cfg_data_i;
        tlik_pkg::CFG_SECOND_LINK: l2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic cs_v, cs_r;
  logic signed [tlik_pkg::QBits-1:0] cs_c;
  logic [tlik_pkg::QBits-1:0] cs_s;
  tlik_pkg::in_item_t cs_item;
  logic [tlik_pkg::LenBits-1:0] cs_l1, cs_l2;

  tlik_cos_sin u_cs (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .item_i(in_item_i),
    .l1_i(l1_q), .l2_i(l2_q),
    .valid_o(cs_v), .reach_o(cs_r), .cos_o(cs_c), .sin_o(cs_s),
    .item_o(cs_item), .l1_o(cs_l1), .l2_o(cs_l2)
  );

  logic rt_v, rt_r;
  logic signed [tlik_pkg::QBits-1:0] rt_c;
  logic [tlik_pkg::QBits-1:0] rt_s;
  logic signed [63:0] rt_p, rt_q;

  tlik_rotate u_rot (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cs_v), .reach_i(cs_r),
    .cos_i(cs_c), .sin_i(cs_s), .item_i(cs_item), .l1_i(cs_l1), .l2_i(cs_l2),
    .valid_o(rt_v), .reach_o(rt_r), .cos_o(rt_c), .sin_o(rt_s), .p_o(rt_p), .q_o(rt_q)
  );

  logic a1_v, a2_v, a2_r;
  logic signed [tlik_pkg::ZBits-1:0] z1, z2;
  logic a1_side;

  tlik_atan2 #(.Stages(CordicStages), .SideW(1)) u_sh (
    .clk_i, .rst_ni, .en_i(en), .valid_i(rt_v), .y_i(rt_p), .x_i(rt_q),
    .side_i(rt_r), .valid_o(a1_v), .z_o(z1), .side_o(a1_side)
  );
  tlik_atan2 #(.Stages(CordicStages), .SideW(1)) u_el (
    .clk_i, .rst_ni, .en_i(en), .valid_i(rt_v),
    .y_i(64'(rt_s)), .x_i(64'(rt_c)),
    .side_i(rt_r), .valid_o(a2_v), .z_o(z2), .side_o(a2_r)
  );

  // round, clamp, output register
  logic signed [tlik_pkg::ZBits-1:0] r1, r2;
  tlik_pkg::out_item_t o_d, o_q;
  logic ov_q;
  always_comb begin
    r1 = (z1 + 32'sd256) >>> 9;
    r2 = (z2 + 32'sd256) >>> 9;
    if (r1 < -32'sd23040) r1 = -32'sd23040;
    if (r1 > 32'sd23040) r1 = 32'sd23040;
    if (r2 < 32'sd0) r2 = 32'sd0;
    if (r2 > 32'sd23040) r2 = 32'sd23040;
    o_d.shoulder_angle = a2_r ? 16'(r1) : '0;
    o_d.elbow_angle    = a2_r ? 15'(r2) : '0;
    o_d.reachable      = a2_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= a2_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) o_q <= o_d;
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = o_q;

  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni) a1_v == a2_v)
    else $error("atan2 pipelines out of step");
  a_side: assert property (@(posedge clk_i) disable iff (!rst_ni) a1_v |-> a1_side == a2_r)
    else $error("reach flag mismatch between angle pipelines");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.reachable |->
      out_item_o.shoulder_angle == '0 && out_item_o.elbow_angle == '0)
    else $error("unreachable result carries angles");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");
endmodule

@@ tb/sv/two_link_inverse_kinematics_top_tb.sv @@
`timescale 1ns / 1ps

module two_link_inverse_kinematics_top_tb;

  localparam int unsigned PipeDrain  = 150;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned LongHold   = 400;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  tlik_pkg::in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  tlik_pkg::out_item_t out_item_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_index_i;
  logic [tlik_pkg::LenBits-1:0] cfg_data_i;

  two_link_inverse_kinematics_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // link lengths as the block currently holds them
  longint unsigned link1_len = tlik_pkg::LenReset;
  longint unsigned link2_len = tlik_pkg::LenReset;

  tlik_pkg::in_item_t  target_queue[$];
  tlik_pkg::out_item_t angle_queue[$];

  int unsigned mismatches = 0;
  int unsigned targets_sent = 0;
  int unsigned angles_seen = 0;
  int unsigned reached_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_cnt = 0;
  bit          hold_done = 0;
  bit          in_taken = 0;
  bit          sender_paused = 0;

  longint step_angle [0:22] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1
  };

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned root60(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 60;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring CORDIC, angle in 2^-16 degree
  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while ((mag(x) > mag(y) ? mag(x) : mag(y)) >= (64'd1 << 30)) begin
      x = x >>> 1;
      y = y >>> 1;
    end
    while ((mag(x) > mag(y) ? mag(x) : mag(y)) < (64'd1 << 29)) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 90 * 65536;
      end else begin
        x = -y;
        y = t;
        z = -90 * 65536;
      end
    end
    for (int i = 0; i < tlik_pkg::CordicStages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += (i < 23) ? step_angle[i] : 0;
      end else begin
        x -= dx;
        y += dy;
        z -= (i < 23) ? step_angle[i] : 0;
      end
    end
    return z;
  endfunction

  function automatic longint to_deg128(longint z, longint lo, longint hi);
    longint r;
    r = (z + 256) >>> 9;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic tlik_pkg::out_item_t solve_joints(tlik_pkg::in_item_t tgt);
    tlik_pkg::out_item_t res;
    longint x;
    longint y;
    longint unsigned r2;
    longint unsigned lsum;
    longint unsigned den;
    longint unsigned anum;
    longint unsigned cm;
    longint unsigned s;
    longint c;
    longint k1;
    longint k2;
    bit neg;
    res = '0;
    x = longint'(tgt.target_x);
    y = longint'(tgt.target_y);
    r2 = mag(x) * mag(x) + mag(y) * mag(y);
    lsum = link1_len * link1_len + link2_len * link2_len;
    den = 2 * link1_len * link2_len;
    neg = r2 < lsum;
    anum = neg ? lsum - r2 : r2 - lsum;
    if (den == 0 || anum > den) return res;
    cm = ((anum << 30) + den / 2) / den;
    c = neg ? -longint'(cm) : longint'(cm);
    s = root60((64'd1 << 60) - cm * cm);
    k1 = (longint'(link1_len) <<< 30) + longint'(link2_len) * c;
    k2 = longint'(link2_len) * longint'(s);
    k1 = k1 >>> 17;
    k2 = k2 >>> 17;
    res.shoulder_angle = tlik_pkg::AngBits'(to_deg128(vector_angle(k1 * y - k2 * x,
                                                                   k1 * x + k2 * y),
                                                      -23040, 23040));
    res.elbow_angle = tlik_pkg::ElbowBits'(to_deg128(vector_angle(longint'(s), c),
                                                     0, 23040));
    res.reachable = 1'b1;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // driver: new targets change on the falling edge
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (target_queue.size() > 0 && !sender_paused) begin
        in_item_i <= target_queue.pop_front();
        in_valid_i <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold once traffic is flowing
  always @(negedge clk_i) begin
    if (!hold_done && targets_sent >= 300) begin
      hold_done <= 1'b1;
      hold_cnt <= LongHold;
      out_stall_i <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall_i <= 1'b1;
    end else begin
      recv_gap <= pick_gap();
      out_stall_i <= 1'b0;
    end
  end

  // monitor: predict on input transaction, compare on output transaction
  always @(posedge clk_i) begin
    tlik_pkg::out_item_t exp_item;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        angle_queue.push_back(solve_joints(in_item_i));
        targets_sent <= targets_sent + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        angles_seen <= angles_seen + 1;
        if (angle_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("ERROR: unexpected result %p", out_item_o);
        end else begin
          exp_item = angle_queue.pop_front();
          if (exp_item.reachable) reached_cnt <= reached_cnt + 1;
          if (exp_item.shoulder_angle !== out_item_o.shoulder_angle ||
              exp_item.elbow_angle !== out_item_o.elbow_angle ||
              exp_item.reachable !== out_item_o.reachable) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("ERROR: expected shoulder %0d elbow %0d reach %0b, got %0d %0d %0b",
                       exp_item.shoulder_angle, exp_item.elbow_angle, exp_item.reachable,
                       out_item_o.shoulder_angle, out_item_o.elbow_angle,
                       out_item_o.reachable);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (target_queue.size() != 0 || angle_queue.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (PipeDrain) @(posedge clk_i);
  endtask

  task automatic write_link(input tlik_pkg::cfg_idx_e idx,
                            input logic [tlik_pkg::LenBits-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == tlik_pkg::CFG_FIRST_LINK) link1_len = val;
    else link2_len = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_target(input int x, input int y);
    tlik_pkg::in_item_t t;
    t.target_x = tlik_pkg::CoordBits'(x);
    t.target_y = tlik_pkg::CoordBits'(y);
    target_queue.push_back(t);
  endtask

  // mostly points in the square spanned by +-(link1 + link2), some anywhere in the field range
  task automatic add_random_targets(input int n);
    int reach;
    reach = int'(link1_len + link2_len);
    if (reach > 32767) reach = 32767;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8)
        add_target(int'($urandom_range(0, 2 * reach)) - reach,
                   int'($urandom_range(0, 2 * reach)) - reach);
      else
        add_target(int'($urandom_range(0, 65535)) - 32768,
                   int'($urandom_range(0, 65535)) - 32768);
    end
  endtask

  initial begin
    int unsigned len_sets [7][2] = '{
      '{2048, 2048}, '{1, 1}, '{65535, 65535}, '{0, 2048},
      '{3000, 500}, '{500, 3000}, '{65535, 1}
    };
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = tlik_pkg::CFG_FIRST_LINK;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed points at reset lengths (8 cm each, reach 16 cm)
    add_target(0, 0);
    add_target(4096, 0);
    add_target(0, 4096);
    add_target(-4096, 0);
    add_target(0, -4096);
    add_target(4097, 0);
    add_target(32767, 32767);
    add_target(-32768, -32768);
    add_target(-32768, 32767);
    add_target(2048, 2048);
    add_target(-2048, 1000);
    add_target(-3000, -100);
    add_target(3000, -1);
    add_target(1, 0);
    add_target(-1, -1);
    add_target(2896, 2896);
    add_random_targets(180);
    // pause mid-phase until everything is back
    wait (targets_sent >= 100);
    sender_paused = 1'b1;
    while (angle_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    sender_paused = 1'b0;
    wait_drained();

    for (int p = 1; p < 7; p++) begin
      write_link(tlik_pkg::CFG_FIRST_LINK, tlik_pkg::LenBits'(len_sets[p][0]));
      write_link(tlik_pkg::CFG_SECOND_LINK, tlik_pkg::LenBits'(len_sets[p][1]));
      add_target(0, 0);
      add_target(32767, -32768);
      add_target(int'(len_sets[p][0] + len_sets[p][1] > 32767 ?
                      32767 : len_sets[p][0] + len_sets[p][1]), 0);
      add_random_targets(185);
      wait_drained();
    end

    $display("covered %0d targets over 7 link settings, %0d reachable, %0d unreachable",
             targets_sent, reached_cnt, angles_seen - reached_cnt);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
